// File: src/fmtp_pkg.sv
// ----------------------------------------------------------------------------
// fmtp_pkg
// Types, codes and arithmetic helpers shared by the FM tuner panel controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fmtp_pkg;

  localparam int unsigned NUM_PRESETS   = 6;
  localparam int unsigned CFG_NUM_REGS  = 6;
  localparam int unsigned CFG_AW        = 5;
  localparam int unsigned CFG_DW        = 32;

  localparam logic [7:0]  MAX_CHANNEL   = 8'd210;
  localparam logic [7:0]  CH_RESET      = 8'd65;
  localparam logic [2:0]  MANUAL_SEL    = 3'd6;
  localparam logic [2:0]  LAST_PRESET   = 3'(NUM_PRESETS - 1);
  localparam logic [2:0]  PREV_FROM_MAN = (NUM_PRESETS >= 2) ? 3'(NUM_PRESETS - 2) : 3'd0;
  localparam logic [6:0]  VOL_RESET     = 7'd80;
  localparam logic [6:0]  VOL_MAX       = 7'd100;
  localparam logic [6:0]  VOL_STEP      = 7'd10;
  localparam logic [6:0]  RSSI_RESET    = 7'd50;

  localparam logic [15:0] PWR_UNMUTED   = 16'hD001;
  localparam logic [15:0] PWR_MUTED     = 16'h9001;
  localparam logic [15:0] TUNE_BIT      = 16'h0010;
  localparam logic [15:0] VOL_WORD_BASE = 16'h880F;
  localparam logic [7:0]  MIX_PASSTHRU  = 8'h98;
  localparam logic [7:0]  MIX_DAC_ONLY  = 8'h80;

  // reciprocal multipliers for division by 100
  localparam logic [10:0] RECIP100_S17  = 11'd1311;
  localparam logic [14:0] RECIP100_S21  = 15'd20972;

  localparam logic [7:0] PRESET_RESET [CFG_NUM_REGS] = '{
    8'd65, 8'd49, 8'd57, 8'd166, 8'd158, 8'd176
  };

  typedef enum logic [3:0] {
    EV_START  = 4'd0,
    EV_STOP   = 4'd1,
    EV_PREV   = 4'd2,
    EV_NEXT   = 4'd3,
    EV_UP     = 4'd4,
    EV_DOWN   = 4'd5,
    EV_MUTE   = 4'd6,
    EV_VOLUP  = 4'd7,
    EV_VOLDN  = 4'd8,
    EV_STATUS = 4'd9
  } event_t;

  typedef enum logic [1:0] {
    TW_NONE  = 2'd0,
    TW_FULL  = 2'd1,
    TW_PDOWN = 2'd2
  } tuner_wr_t;

  typedef logic [CFG_NUM_REGS-1:0][7:0] preset_arr_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] status_word_a;
    logic [15:0] status_word_b;
    logic        read_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  tuner_write;
    logic [15:0] power_word;
    logic [15:0] tune_word;
    logic [15:0] volume_word;
    logic        codec_att_write;
    logic [7:0]  codec_attenuation;
    logic        mixer_write;
    logic [7:0]  mixer_value;
    logic [2:0]  preset_index;
    logic        stereo;
    logic [6:0]  rssi;
    logic        status_changed;
  } out_item_t;

  typedef struct packed {
    logic       active;
    logic [7:0] channel;
    logic [2:0] preset_sel;
    logic [6:0] volume;
    logic       muted;
    logic       stereo;
    logic [6:0] rssi;
  } ctl_state_t;

  // min(volume*15/100, 15)
  function automatic logic [3:0] volume_nibble(input logic [6:0] vol);
    logic [10:0] x;
    logic [21:0] p;
    logic [4:0]  q;
    x = 11'(vol) * 11'd15;
    p = 22'(x) * 22'(RECIP100_S17);
    q = p[21:17];
    return (q > 5'd15) ? 4'd15 : q[3:0];
  endfunction

  // (100 - volume)*192/100, volume at most 100
  function automatic logic [7:0] codec_att(input logic [6:0] vol);
    logic [6:0]  d;
    logic [14:0] y;
    logic [29:0] p;
    d = VOL_MAX - vol;
    y = 15'(d) * 15'd192;
    p = 30'(y) * 30'(RECIP100_S21);
    return p[28:21];
  endfunction

  function automatic logic [7:0] clamp_channel(input logic [7:0] ch);
    return (ch > MAX_CHANNEL) ? MAX_CHANNEL : ch;
  endfunction

endpackage

`default_nettype wire

// File: src/fmtp_if.sv
// ----------------------------------------------------------------------------
// fmtp_if
// Valid/ready channels for panel events and controller results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmtp_in_if;
  import fmtp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fmtp_out_if;
  import fmtp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/fm_tuner_panel_controller.sv
// ----------------------------------------------------------------------------
// fm_tuner_panel_controller
// Front-panel event handling for an FM tuner: presets, stepping, volume,
// mute and status tracking, producing tuner and codec register settings.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_ch    | sink      | valid/ready          | func, status words, read_ok
//  out_ch   | source    | valid/ready          | register words and status
//  APB      | slave     | psel/penable, pready | six 8-bit preset channels
//
// One event per clock while out_ch is not stalled; each event is held in the
// input register, and its result is then registered in the output register.
// Both stages advance together whenever the output register is empty or taken.
// A stall on out_ch holds both stages; the input register still absorbs one
// event. Synchronous active-low reset restores the power-on panel state.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_tuner_panel_controller (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  fmtp_in_if.sink                           in_ch,
  fmtp_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fmtp_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [fmtp_pkg::CFG_DW-1:0]  pwdata,
  output logic      [fmtp_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready
);
  import fmtp_pkg::*;

  preset_arr_t presets;

  logic       in_vld_r;
  in_item_t   in_itm_r;
  logic       out_vld_r;
  out_item_t  out_itm_r;
  ctl_state_t st_r;
  ctl_state_t st_nxt;
  out_item_t  res_nxt;
  logic       adv;
  logic [7:0] match_ch;
  logic [2:0] match_sel;
  logic [3:0] lvl;

  fmtp_presets u_presets (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .presets (presets)
  );

  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = !in_vld_r || adv;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_itm_r;

  // channel after an up/down step, and the first preset that equals it
  always_comb begin
    match_ch = st_r.channel;
    if (in_itm_r.func == EV_UP) begin
      match_ch = (st_r.channel >= MAX_CHANNEL) ? 8'd0 : st_r.channel + 8'd1;
    end else begin
      match_ch = (st_r.channel == 8'd0 || st_r.channel > MAX_CHANNEL) ?
                 MAX_CHANNEL : st_r.channel - 8'd1;
    end
    match_sel = MANUAL_SEL;
    for (int i = NUM_PRESETS - 1; i >= 0; i--) begin
      if (presets[i] == match_ch) begin
        match_sel = 3'(i);
      end
    end
  end

  always_comb begin
    st_nxt  = st_r;
    res_nxt = '0;
    if (in_itm_r.func == EV_START) begin
      if (!st_r.active) begin
        st_nxt.active      = 1'b1;
        st_nxt.muted       = 1'b0;
        st_nxt.preset_sel  = 3'd0;
        st_nxt.channel     = clamp_channel(presets[0]);
        res_nxt.mixer_write = 1'b1;
        res_nxt.mixer_value = MIX_PASSTHRU;
        res_nxt.tuner_write = TW_FULL;
      end
    end else if (st_r.active) begin
      case (in_itm_r.func)
        EV_STOP: begin
          st_nxt.active       = 1'b0;
          res_nxt.tuner_write = TW_PDOWN;
          res_nxt.mixer_write = 1'b1;
          res_nxt.mixer_value = MIX_DAC_ONLY;
        end
        EV_PREV: begin
          if (st_r.preset_sel > LAST_PRESET) begin
            st_nxt.preset_sel = PREV_FROM_MAN;
          end else if (st_r.preset_sel == 3'd0) begin
            st_nxt.preset_sel = LAST_PRESET;
          end else begin
            st_nxt.preset_sel = st_r.preset_sel - 3'd1;
          end
          st_nxt.channel      = clamp_channel(presets[st_nxt.preset_sel]);
          res_nxt.tuner_write = TW_FULL;
        end
        EV_NEXT: begin
          if (st_r.preset_sel >= LAST_PRESET) begin
            st_nxt.preset_sel = 3'd0;
          end else begin
            st_nxt.preset_sel = st_r.preset_sel + 3'd1;
          end
          st_nxt.channel      = clamp_channel(presets[st_nxt.preset_sel]);
          res_nxt.tuner_write = TW_FULL;
        end
        EV_UP, EV_DOWN: begin
          st_nxt.channel      = match_ch;
          st_nxt.preset_sel   = match_sel;
          res_nxt.tuner_write = TW_FULL;
        end
        EV_MUTE: begin
          st_nxt.muted        = !st_r.muted;
          res_nxt.tuner_write = TW_FULL;
        end
        EV_VOLUP, EV_VOLDN: begin
          if (in_itm_r.func == EV_VOLUP) begin
            st_nxt.volume = (st_r.volume + VOL_STEP > VOL_MAX) ? VOL_MAX :
                            st_r.volume + VOL_STEP;
          end else begin
            st_nxt.volume = (st_r.volume < VOL_STEP) ? 7'd0 : st_r.volume - VOL_STEP;
          end
          res_nxt.codec_att_write   = 1'b1;
          res_nxt.codec_attenuation = codec_att(st_nxt.volume);
          res_nxt.tuner_write       = TW_FULL;
        end
        EV_STATUS: begin
          if (in_itm_r.read_ok &&
              (in_itm_r.status_word_a[10] != st_r.stereo ||
               in_itm_r.status_word_b[15:9] != st_r.rssi)) begin
            st_nxt.stereo          = in_itm_r.status_word_a[10];
            st_nxt.rssi            = in_itm_r.status_word_b[15:9];
            res_nxt.status_changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    lvl = volume_nibble(st_nxt.volume);
    if (res_nxt.tuner_write == TW_FULL) begin
      res_nxt.power_word  = st_nxt.muted ? PWR_MUTED : PWR_UNMUTED;
      res_nxt.tune_word   = {2'b00, st_nxt.channel[7:0], 6'b0} | TUNE_BIT;
      res_nxt.volume_word = VOL_WORD_BASE | {8'd0, lvl, 4'd0};
    end
    res_nxt.preset_index = st_nxt.preset_sel;
    res_nxt.stereo       = st_nxt.stereo;
    res_nxt.rssi         = st_nxt.rssi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{active: 1'b0, channel: CH_RESET, preset_sel: 3'd0,
                     volume: VOL_RESET, muted: 1'b0, stereo: 1'b1, rssi: RSSI_RESET};
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_itm_r <= in_ch.data;
    end
    if (adv && in_vld_r) begin
      out_itm_r <= res_nxt;
    end
  end

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.preset_sel <= MANUAL_SEL)
    else $error("preset selection out of range");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.channel <= MAX_CHANNEL)
    else $error("channel beyond band edge");

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.volume <= VOL_MAX)
    else $error("volume beyond maximum");

  a_idle_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_itm_r.tuner_write != TW_FULL |->
      out_itm_r.power_word == 16'd0 && out_itm_r.tune_word == 16'd0)
    else $error("tuner words set without a full write");

  a_mixer_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_itm_r.mixer_write |-> out_itm_r.tuner_write != TW_NONE)
    else $error("mixer write without tuner write");

endmodule

`default_nettype wire

// File: src/fmtp_presets.sv
// ----------------------------------------------------------------------------
// fmtp_presets
// APB register file holding the preset channels.
// ----------------------------------------------------------------------------
`default_nettype none

module fmtp_presets (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fmtp_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [fmtp_pkg::CFG_DW-1:0]  pwdata,
  output logic      [fmtp_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready,
  output fmtp_pkg::preset_arr_t             presets
);
  import fmtp_pkg::*;

  logic [2:0]  reg_idx;
  logic        idx_ok;
  preset_arr_t preset_r;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign idx_ok  = (32'(reg_idx) < CFG_NUM_REGS);
  assign pready  = 1'b1;
  assign presets = preset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM_REGS; i++) begin
        preset_r[i] <= PRESET_RESET[i];
      end
    end else if (psel && penable && pwrite && idx_ok) begin
      preset_r[reg_idx] <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = CFG_DW'(preset_r[reg_idx]);
    end
  end

endmodule

`default_nettype wire
